[rtl/bti_pkg.sv]
// Shared types, register codes and lane helper for the block transpose index calculator.
package bti_pkg;

  localparam int LANE_BITS = 16;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 64;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_LEVEL_COUNT = 3'd0,
    CFG_LEVEL_ROWS  = 3'd1,
    CFG_LEVEL_COLS  = 3'd2,
    CFG_TRANSPOSE   = 3'd3,
    CFG_IN_ROWS     = 3'd4,
    CFG_IN_COLS     = 3'd5,
    CFG_OUT_COLS    = 3'd6
  } cfg_reg_t;

  // Block sizes seen by one blocking level; zero sizes turn the level into a pass-through.
  typedef struct packed {
    logic [LANE_BITS-1:0] blk_rows;
    logic [LANE_BITS-1:0] blk_cols;
    logic [LANE_BITS-1:0] outer_cols;
  } bti_lvl_cfg_t;

  function automatic logic [LANE_BITS-1:0] lane_get(input logic [CFG_DATA_BITS-1:0] packed_val,
                                                    input logic [1:0] k);
    lane_get = packed_val[LANE_BITS*k +: LANE_BITS];
  endfunction

endpackage

[rtl/bti_div_cell.sv]
// One restoring division step: shifts in one dividend bit and produces one quotient bit.
module bti_div_cell #(
  parameter int NB = 16,
  parameter int DB = 16,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [DB-1:0] div,
  input  logic          in_v,
  input  logic [NB-1:0] in_rem,
  input  logic [NB-1:0] in_a,
  input  logic [PW-1:0] in_pay,
  output logic          out_v,
  output logic [NB-1:0] out_rem,
  output logic [NB-1:0] out_a,
  output logic [PW-1:0] out_pay
);

  logic          v_r;
  logic [NB-1:0] rem_r, rem_nxt;
  logic [NB-1:0] a_r, a_nxt;
  logic [PW-1:0] pay_r;
  logic [NB:0]   sh;
  logic [NB:0]   diff;
  logic          ge;

  // A zero divisor never subtracts, so the remainder collects the whole dividend.
  always_comb begin
    sh      = {in_rem, in_a[NB-1]};
    diff    = sh - (NB+1)'(div);
    ge      = (div != '0) && (sh >= (NB+1)'(div));
    rem_nxt = ge ? diff[NB-1:0] : sh[NB-1:0];
    a_nxt   = {in_a[NB-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    a_r   <= a_nxt;
    pay_r <= in_pay;
  end

  assign out_v   = v_r;
  assign out_rem = rem_r;
  assign out_a   = a_r;
  assign out_pay = pay_r;

endmodule

[rtl/bti_div_pipe.sv]
// Chain of restoring division cells, one quotient bit per stage, with a carried payload.
module bti_div_pipe #(
  parameter int NB = 16,
  parameter int DB = 16,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [DB-1:0] div,
  input  logic          in_v,
  input  logic [NB-1:0] in_a,
  input  logic [PW-1:0] in_pay,
  output logic          out_v,
  output logic [NB-1:0] out_q,
  output logic [NB-1:0] out_rem,
  output logic [PW-1:0] out_pay
);

  logic          v_c   [NB+1];
  logic [NB-1:0] rem_c [NB+1];
  logic [NB-1:0] a_c   [NB+1];
  logic [PW-1:0] pay_c [NB+1];

  assign v_c[0]   = in_v;
  assign rem_c[0] = '0;
  assign a_c[0]   = in_a;
  assign pay_c[0] = in_pay;

  for (genvar i = 0; i < NB; i++) begin : g_cell
    bti_div_cell #(.NB(NB), .DB(DB), .PW(PW)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .div     (div),
      .in_v    (v_c[i]),
      .in_rem  (rem_c[i]),
      .in_a    (a_c[i]),
      .in_pay  (pay_c[i]),
      .out_v   (v_c[i+1]),
      .out_rem (rem_c[i+1]),
      .out_a   (a_c[i+1]),
      .out_pay (pay_c[i+1])
    );
  end

  assign out_v   = v_c[NB];
  assign out_q   = a_c[NB];
  assign out_rem = rem_c[NB];
  assign out_pay = pay_c[NB];

endmodule

[rtl/bti_level.sv]
// One blocking level: splits row and column by block size and adds the block offset.
module bti_level #(
  parameter int D  = 16,
  parameter int NW = 35
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bti_pkg::bti_lvl_cfg_t cfg,
  input  logic                 in_v,
  input  logic [D-1:0]         in_r,
  input  logic [D-1:0]         in_c,
  input  logic [NW-1:0]        in_n,
  output logic                 out_v,
  output logic [D-1:0]         out_r,
  output logic [D-1:0]         out_c,
  output logic [NW-1:0]        out_n
);

  localparam int PW1 = 2*D + NW;
  localparam int PW2 = 3*D + NW;

  logic [D-1:0]   br, bc, oc;
  logic           v1;
  logic [D-1:0]   rr;
  logic [PW1-1:0] pay1;
  logic           v2;
  logic [D-1:0]   rc;
  logic [PW2-1:0] pay2;
  logic [D-1:0]   r2, c2, rr2;
  logic [NW-1:0]  n2;

  logic           m_v_r;
  logic [2*D-1:0] m_t1_r, m_t2_r;
  logic [D-1:0]   m_rr_r, m_rc_r;
  logic [NW-1:0]  m_n_r;
  logic           a_v_r;
  logic [D-1:0]   a_r_r, a_c_r;
  logic [NW-1:0]  a_n_r, a_n_nxt;

  assign br = cfg.blk_rows[D-1:0];
  assign bc = cfg.blk_cols[D-1:0];
  assign oc = cfg.outer_cols[D-1:0];

  bti_div_pipe #(.NB(D), .DB(D), .PW(PW1)) u_div_row (
    .clk     (clk),
    .rst_n   (rst_n),
    .div     (br),
    .in_v    (in_v),
    .in_a    (in_r),
    .in_pay  ({in_r, in_c, in_n}),
    .out_v   (v1),
    .out_q   (),
    .out_rem (rr),
    .out_pay (pay1)
  );

  bti_div_pipe #(.NB(D), .DB(D), .PW(PW2)) u_div_col (
    .clk     (clk),
    .rst_n   (rst_n),
    .div     (bc),
    .in_v    (v1),
    .in_a    (pay1[NW +: D]),
    .in_pay  ({pay1, rr}),
    .out_v   (v2),
    .out_q   (),
    .out_rem (rc),
    .out_pay (pay2)
  );

  assign rr2 = pay2[D-1:0];
  assign n2  = pay2[D +: NW];
  assign c2  = pay2[D+NW +: D];
  assign r2  = pay2[2*D+NW +: D];

  // Whole blocks skipped: rows give (r - rr) * outer cols, columns give (c - rc) * block rows.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
      a_v_r <= 1'b0;
    end else begin
      m_v_r <= v2;
      a_v_r <= m_v_r;
    end
  end

  assign a_n_nxt = m_n_r + NW'(m_t1_r) + NW'(m_t2_r);

  always_ff @(posedge clk) begin
    m_t1_r <= (r2 - rr2) * oc;
    m_t2_r <= (c2 - rc) * br;
    m_rr_r <= rr2;
    m_rc_r <= rc;
    m_n_r  <= n2;
    a_r_r  <= m_rr_r;
    a_c_r  <= m_rc_r;
    a_n_r  <= a_n_nxt;
  end

  assign out_v = a_v_r;
  assign out_r = a_r_r;
  assign out_c = a_c_r;
  assign out_n = a_n_r;

endmodule

[rtl/block_transpose_index_calc_core.sv]
// Top level of the block transpose index calculator: config registers, level chain, final split.
//
//  channel | ports                                    | handshake
//  --------+------------------------------------------+-----------------------------
//  input   | in_out_row, in_out_col                   | start & !busy, one beat/cycle
//  result  | out_in_index, out_past_end               | out_strobe, one cycle, no stall
//  config  | cfg_we, cfg_index, cfg_wdata             | write on cfg_we, no wait
//
// One beat is accepted every cycle; busy is always low.
// The pipeline is the chain of division cells plus product and sum registers: two DIM_BITS-cell
// dividers per blocking level and a (2*DIM_BITS+3)-cell divider for the transpose split.
// Reset clears the valid chain and resets the config registers.
// The receiver cannot stall, so results leave strictly in order, one per accepted beat.
module block_transpose_index_calc_core #(
  parameter int MAX_LEVELS = 4,
  parameter int DIM_BITS   = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [15:0]                       in_out_row,
  input  logic [15:0]                       in_out_col,
  output logic                              out_strobe,
  output logic [31:0]                       out_in_index,
  output logic                              out_past_end,
  input  logic                              cfg_we,
  input  logic [bti_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [bti_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int D   = DIM_BITS;
  localparam int NW  = 2*D + 3;
  localparam int FW  = NW + D + 1;
  localparam int LAT = (MAX_LEVELS-1)*(2*D+2) + 2 + NW + 2;

  logic [2:0]  level_count_r;
  logic [63:0] level_rows_r;
  logic [63:0] level_cols_r;
  logic        transpose_r;
  logic [15:0] in_rows_r, in_cols_r, out_cols_r;
  logic [2*D-1:0] total_r;

  logic [2:0]   lv;
  logic [1:0]   klast;
  logic         blk;
  logic [D-1:0] ir, ic, oc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_count_r <= 3'd1;
      level_rows_r  <= '0;
      level_cols_r  <= '0;
      transpose_r   <= 1'b0;
      in_rows_r     <= '0;
      in_cols_r     <= '0;
      out_cols_r    <= '0;
    end else if (cfg_we) begin
      case (bti_pkg::cfg_reg_t'(cfg_index))
        bti_pkg::CFG_LEVEL_COUNT: level_count_r <= cfg_wdata[2:0];
        bti_pkg::CFG_LEVEL_ROWS:  level_rows_r  <= cfg_wdata;
        bti_pkg::CFG_LEVEL_COLS:  level_cols_r  <= cfg_wdata;
        bti_pkg::CFG_TRANSPOSE:   transpose_r   <= cfg_wdata[0];
        bti_pkg::CFG_IN_ROWS:     in_rows_r     <= cfg_wdata[15:0];
        bti_pkg::CFG_IN_COLS:     in_cols_r     <= cfg_wdata[15:0];
        bti_pkg::CFG_OUT_COLS:    out_cols_r    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign lv    = (level_count_r > 3'(MAX_LEVELS)) ? 3'(MAX_LEVELS) : level_count_r;
  assign blk   = lv > 3'd1;
  assign klast = blk ? 2'(lv - 3'd1) : 2'd0;
  assign ir    = in_rows_r[D-1:0];
  assign ic    = in_cols_r[D-1:0];
  assign oc    = out_cols_r[D-1:0];

  always_ff @(posedge clk) begin
    total_r <= ir * ic;
  end

  assign busy = 1'b0;

  // Level chain: stage k is active only while k+1 < levels; otherwise its block sizes are zero.
  logic          st_v [MAX_LEVELS];
  logic [D-1:0]  st_r [MAX_LEVELS];
  logic [D-1:0]  st_c [MAX_LEVELS];
  logic [NW-1:0] st_n [MAX_LEVELS];

  assign st_v[0] = start & ~busy;
  assign st_r[0] = in_out_row[D-1:0];
  assign st_c[0] = in_out_col[D-1:0];
  assign st_n[0] = '0;

  for (genvar k = 0; k < MAX_LEVELS-1; k++) begin : g_level
    bti_pkg::bti_lvl_cfg_t lcfg;
    logic                  act;

    assign act = (3'(k+1) < lv);
    assign lcfg.blk_rows   = act ? bti_pkg::lane_get(level_rows_r, 2'(k+1)) : '0;
    assign lcfg.blk_cols   = act ? bti_pkg::lane_get(level_cols_r, 2'(k+1)) : '0;
    assign lcfg.outer_cols = bti_pkg::lane_get(level_cols_r, 2'(k));

    bti_level #(.D(D), .NW(NW)) u_level (
      .clk   (clk),
      .rst_n (rst_n),
      .cfg   (lcfg),
      .in_v  (st_v[k]),
      .in_r  (st_r[k]),
      .in_c  (st_c[k]),
      .in_n  (st_n[k]),
      .out_v (st_v[k+1]),
      .out_r (st_r[k+1]),
      .out_c (st_c[k+1]),
      .out_n (st_n[k+1])
    );
  end

  // Final row/column combine, shared by blocked, direct-transpose and row-major order.
  logic           f1_v_r, f2_v_r;
  logic [2*D-1:0] f1_prod_r;
  logic [D-1:0]   f1_add_r;
  logic [NW-1:0]  f1_n_r, f2_n_r;
  logic           f1_dot_r, f2_dot_r;
  logic [D-1:0]   fx, fy, fadd;
  logic [bti_pkg::LANE_BITS-1:0] fy_lane;

  assign fy_lane = bti_pkg::lane_get(level_cols_r, klast);

  always_comb begin
    fx   = (blk || !transpose_r) ? st_r[MAX_LEVELS-1] : st_c[MAX_LEVELS-1];
    fadd = (blk || !transpose_r) ? st_c[MAX_LEVELS-1] : st_r[MAX_LEVELS-1];
    if (blk) begin
      fy = fy_lane[D-1:0];
    end else if (transpose_r) begin
      fy = ic;
    end else begin
      fy = oc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else begin
      f1_v_r <= st_v[MAX_LEVELS-1];
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    f1_prod_r <= fx * fy;
    f1_add_r  <= fadd;
    f1_n_r    <= st_n[MAX_LEVELS-1];
    f1_dot_r  <= blk & transpose_r;
    f2_n_r    <= f1_n_r + NW'(f1_prod_r) + NW'(f1_add_r);
    f2_dot_r  <= f1_dot_r;
  end

  // Re-split by input rows; a zero divisor leaves the index whole in the remainder.
  logic          dv_v;
  logic [NW-1:0] dv_q, dv_rem;
  logic [0:0]    dv_dot;
  logic [D-1:0]  tdiv;

  assign tdiv = (blk && transpose_r) ? ir : '0;

  bti_div_pipe #(.NB(NW), .DB(D), .PW(1)) u_div_tr (
    .clk     (clk),
    .rst_n   (rst_n),
    .div     (tdiv),
    .in_v    (f2_v_r),
    .in_a    (f2_n_r),
    .in_pay  (f2_dot_r),
    .out_v   (dv_v),
    .out_q   (dv_q),
    .out_rem (dv_rem),
    .out_pay (dv_dot)
  );

  logic            g1_v_r;
  logic [NW+D-1:0] g1_prod_r;
  logic [NW-1:0]   g1_q_r, g1_rem_r;
  logic            g1_dot_r;
  logic [FW-1:0]   nf;
  logic [63:0]     nf64;
  logic            o_v_r;
  logic [31:0]     o_index_r;
  logic            o_past_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      g1_v_r <= dv_v;
      o_v_r  <= g1_v_r;
    end
  end

  assign nf   = g1_dot_r ? (FW'(g1_prod_r) + FW'(g1_q_r)) : FW'(g1_rem_r);
  assign nf64 = 64'(nf);

  always_ff @(posedge clk) begin
    g1_prod_r <= dv_rem * ic;
    g1_q_r    <= dv_q;
    g1_rem_r  <= dv_rem;
    g1_dot_r  <= dv_dot[0];
    o_index_r <= nf64[31:0];
    o_past_r  <= nf >= FW'(total_r);
  end

  assign out_strobe   = o_v_r;
  assign out_in_index = o_index_r;
  assign out_past_end = o_past_r;

  // Every result beat must trace back to an accepted beat at the pipeline input.
  a_strobe_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, LAT))
    else $error("result beat without a matching accepted beat");

  // An empty input matrix puts every index past the end.
  a_empty_past_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && ($past(total_r) == '0)) |-> out_past_end)
    else $error("past_end low with empty input matrix");

endmodule

[tb/block_transpose_index_calc_core_tb.sv]
// Self-checking testbench for the block transpose index calculator core.
`timescale 1ns / 1ps

module block_transpose_index_calc_core_tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [15:0] in_out_row = '0;
  logic [15:0] in_out_col = '0;
  logic out_strobe;
  logic [31:0] out_in_index;
  logic out_past_end;
  logic cfg_we = 1'b0;
  logic [bti_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [bti_pkg::CFG_DATA_BITS-1:0] cfg_wdata = '0;

  block_transpose_index_calc_core u_top (.*);

  always #5 clk = ~clk;

  // Shadow copy of the register file.
  logic [2:0] m_level_count;
  logic [63:0] m_level_rows;
  logic [63:0] m_level_cols;
  logic m_transpose;
  logic [15:0] m_in_rows;
  logic [15:0] m_in_cols;
  logic [15:0] m_out_cols;

  typedef struct packed {
    logic [31:0] in_index;
    logic past_end;
  } index_result_t;

  index_result_t pending_indexes[$];
  int n_errors = 0;
  int n_items = 0;
  int n_checked = 0;
  int n_settings = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  function automatic logic [63:0] div_or_zero(input logic [63:0] a, input logic [63:0] b);
    return (b == 0) ? 64'd0 : a / b;
  endfunction

  function automatic index_result_t predict_index(input logic [15:0] row, input logic [15:0] col);
    logic [63:0] r, c, n, br, bc, oc, sr, sc, q, ir, ic;
    int levels;
    index_result_t res;
    r = 64'(row);
    c = 64'(col);
    ir = 64'(m_in_rows);
    ic = 64'(m_in_cols);
    levels = (m_level_count > 4) ? 4 : m_level_count;
    n = 0;
    if (levels > 1) begin
      for (int k = 0; k < levels - 1; k++) begin
        br = 64'(m_level_rows[16*(k+1) +: 16]);
        bc = 64'(m_level_cols[16*(k+1) +: 16]);
        oc = 64'(m_level_cols[16*k +: 16]);
        sr = div_or_zero(r, br);
        sc = div_or_zero(c, bc);
        r = r - sr * br;
        c = c - sc * bc;
        n = n + sr * br * oc + sc * br * bc;
      end
      n = n + r * 64'(m_level_cols[16*(levels-1) +: 16]) + c;
      if (m_transpose) begin
        q = div_or_zero(n, ir);
        n = (n - q * ir) * ic + q;
      end
    end else if (m_transpose) begin
      n = c * ic + r;
    end else begin
      n = r * 64'(m_out_cols) + c;
    end
    res.in_index = n[31:0];
    res.past_end = (n >= ir * ic);
    return res;
  endfunction

  // Sends one beat; the sender works in bursts, most of them separated by random gaps.
  task automatic send_item(input logic [15:0] row, input logic [15:0] col);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    burst_left--;
    in_out_row <= row;
    in_out_col <= col;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_indexes.push_back(predict_index(row, col));
    n_items++;
  endtask

  // Lowers start and waits until every expected beat has come back.
  task automatic drain_results();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_indexes.size() != 0) @(posedge clk);
  endtask

  // Raises the write enable and waits on the clock; the caller lowers it after the last write.
  task automatic write_reg(input bti_pkg::cfg_reg_t idx, input logic [63:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      bti_pkg::CFG_LEVEL_COUNT: m_level_count = data[2:0];
      bti_pkg::CFG_LEVEL_ROWS:  m_level_rows = data;
      bti_pkg::CFG_LEVEL_COLS:  m_level_cols = data;
      bti_pkg::CFG_TRANSPOSE:   m_transpose = data[0];
      bti_pkg::CFG_IN_ROWS:     m_in_rows = data[15:0];
      bti_pkg::CFG_IN_COLS:     m_in_cols = data[15:0];
      bti_pkg::CFG_OUT_COLS:    m_out_cols = data[15:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [2:0] levels, input logic [63:0] rows_p,
                            input logic [63:0] cols_p, input logic tr,
                            input logic [15:0] ir, input logic [15:0] ic, input logic [15:0] oc);
    drain_results();
    write_reg(bti_pkg::CFG_LEVEL_COUNT, {$urandom, $urandom} & ~64'h7 | 64'(levels));
    write_reg(bti_pkg::CFG_LEVEL_ROWS, rows_p);
    write_reg(bti_pkg::CFG_LEVEL_COLS, cols_p);
    write_reg(bti_pkg::CFG_TRANSPOSE, {63'd0, tr});
    write_reg(bti_pkg::CFG_IN_ROWS, {$urandom, 16'd0, ir});
    write_reg(bti_pkg::CFG_IN_COLS, {48'd0, ic});
    write_reg(bti_pkg::CFG_OUT_COLS, {48'd0, oc});
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic test_plain_order();
    set_config(3'd1, '0, '0, 1'b0, 16'd100, 16'd200, 16'd200);
    send_item(16'd0, 16'd0);
    send_item(16'd99, 16'd199);
    send_item(16'd100, 16'd0);
    set_config(3'd0, '1, '1, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(16'hFFFF, 16'hFFFF);
    send_item(16'hFFFE, 16'hFFFF);
    send_item(16'h0000, 16'hFFFF);
  endtask

  task automatic test_direct_transpose();
    set_config(3'd1, '0, '0, 1'b1, 16'd30, 16'd40, 16'd0);
    send_item(16'd29, 16'd39);
    send_item(16'd5, 16'd7);
    send_item(16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_blocked();
    // Two levels: 8x8 matrix of 4x4 blocks.
    set_config(3'd2, 64'h0000_0000_0004_0008, 64'h0000_0000_0004_0008, 1'b0,
               16'd8, 16'd8, 16'd0);
    send_item(16'd0, 16'd0);
    send_item(16'd5, 16'd6);
    send_item(16'd7, 16'd7);
    // Zero block sizes leave the level as a pass-through.
    set_config(3'd4, 64'h0000_0002_0000_0010, 64'h0003_0000_0000_0010, 1'b0,
               16'd16, 16'd16, 16'd0);
    send_item(16'd9, 16'd11);
    send_item(16'd15, 16'd2);
    // Too many levels folds to the maximum; big lanes give an index past 32 bits.
    set_config(3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_8000_4000_FFFF, 1'b0,
               16'hFFFF, 16'hFFFF, 16'd0);
    send_item(16'hFFFF, 16'hFFFF);
    send_item(16'h8001, 16'h7FFF);
  endtask

  task automatic test_blocked_transpose();
    set_config(3'd2, 64'h0000_0000_0002_0006, 64'h0000_0000_0003_0009, 1'b1,
               16'd6, 16'd9, 16'd0);
    send_item(16'd4, 16'd7);
    send_item(16'd5, 16'd8);
    // No input rows: the whole blocked index stays as the remainder.
    set_config(3'd3, 64'h0000_0004_0008_0010, 64'h0000_0004_0008_0010, 1'b1,
               16'd0, 16'd16, 16'd0);
    send_item(16'd13, 16'd9);
    // Empty input puts every index past the end.
    set_config(3'd2, 64'h0000_0000_0001_0001, 64'h0000_0000_0001_0001, 1'b1,
               16'd5, 16'd0, 16'd0);
    send_item(16'd0, 16'd0);
  endtask

  function automatic logic [15:0] rand_dim(input int mode);
    case (mode)
      0: return 16'($urandom);
      1: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(0, 64));
    endcase
  endfunction

  task automatic test_random();
    logic [63:0] rows_p, cols_p;
    logic [15:0] ir, ic;
    int mode;
    for (int ph = 0; ph < 19; ph++) begin
      mode = $urandom_range(0, 5);
      for (int k = 0; k < 4; k++) begin
        rows_p[16*k +: 16] = ($urandom_range(0, 9) == 0) ? 16'd0 : rand_dim(mode > 1 ? 2 : mode);
        cols_p[16*k +: 16] = ($urandom_range(0, 9) == 0) ? 16'd0 : rand_dim(mode > 1 ? 2 : mode);
      end
      ir = rand_dim(mode > 2 ? 2 : $urandom_range(0, 2));
      ic = rand_dim(mode > 2 ? 2 : $urandom_range(0, 2));
      set_config(3'($urandom_range(0, 7)), rows_p, cols_p, 1'($urandom_range(0, 1)), ir, ic,
                 rand_dim($urandom_range(0, 2)));
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(0, 1) != 0) send_item(16'($urandom), 16'($urandom));
        else send_item(16'($urandom_range(0, 80)), 16'($urandom_range(0, 80)));
      end
    end
  endtask

  // Checks every result beat against the oldest prediction.
  always @(posedge clk) begin
    index_result_t want;
    if (rst_n && out_strobe) begin
      if (pending_indexes.size() == 0) begin
        $display("%0t: unexpected result beat index=%0h past_end=%0b",
                 $realtime, out_in_index, out_past_end);
        n_errors++;
      end else begin
        want = pending_indexes.pop_front();
        n_checked++;
        if (out_in_index !== want.in_index) begin
          $display("%0t: in_index expected %0h actual %0h", $realtime, want.in_index, out_in_index);
          n_errors++;
        end
        if (out_past_end !== want.past_end) begin
          $display("%0t: past_end expected %0b actual %0b", $realtime, want.past_end,
                   out_past_end);
          n_errors++;
        end
      end
    end
  end

  // Ends the run if neither side nor the register port moves for too long.
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || cfg_we || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    m_level_count = 3'd1;
    m_level_rows = '0;
    m_level_cols = '0;
    m_transpose = 1'b0;
    m_in_rows = '0;
    m_in_cols = '0;
    m_out_cols = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Reset values alone: one level, plain order, every index past the end.
    send_item(16'd3, 16'd4);
    test_plain_order();
    test_direct_transpose();
    test_blocked();
    test_blocked_transpose();
    test_random();
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_indexes.size() != 0) n_errors++;
    $display("Sent %0d beats over %0d register settings, checked %0d results.",
             n_items, n_settings, n_checked);
    $display("Covered plain, transposed and blocked orders, folded levels and zero sizes.");
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
